// ===== hw/rtl/hls_to_rgb_integer_core_macros.svh =====
`ifndef HLS_TO_RGB_INTEGER_CORE_MACROS_SVH
`define HLS_TO_RGB_INTEGER_CORE_MACROS_SVH

// check a condition on every clock edge outside reset
`define HRGB_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check that an antecedent implies a consequent sequence
`define HRGB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hlsrgb_pkg.sv =====
`timescale 1ns / 1ps

package hlsrgb_pkg;

  // field widths
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;
  localparam int CHAN_W = 8;

  // angles and levels
  localparam int FULL_TURN  = 360;
  localparam int SIXTY      = 60;
  localparam int HALF_TURN  = 180;
  localparam int TWO_FORTY  = 240;
  localparam int THIRD_TURN = 120;
  localparam int PERCENT    = 100;
  localparam int MID_LIGHT  = 50;

  // reciprocal constants: floor(n / 100) = (n * M100) >> 24 for n < 199728
  localparam logic [17:0] M100  = 18'd167773;
  localparam int          SH100 = 24;
  // floor(n / 60) = (n * M60) >> 22 for n < 74898
  localparam logic [16:0] M60   = 17'd69906;
  localparam int          SH60  = 22;

  // pipeline depth from start to done
  localparam int LATENCY = 5;

  // piece of the channel curve that a shifted hue falls on
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // wrap a shifted hue into 0..360 (360 itself is kept)
  function automatic logic [HUE_W-1:0] wrap_hue(input logic signed [10:0] x);
    logic signed [10:0] y;
    y = x;
    if (y > 11'sd360) y = y - 11'sd360;
    if (y < 11'sd0)   y = y + 11'sd360;
    return y[HUE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/hls_to_rgb_integer_core.sv =====
`timescale 1ns / 1ps
// HLS to RGB conversion, integer arithmetic, five register stages.
//
// Input transaction: hue (degrees), lightness and saturation (percent) are
// taken at a rising edge where start is high and busy is low. busy is
// always low: the pipeline takes a new transaction every cycle.
// Output transaction: red, green and blue are valid for exactly one cycle
// while done is high. The receiver cannot stall, so nothing holds the
// pipeline and no result is ever dropped or repeated.
// Path: the accepting edge loads the stage 1 registers, and the result
// is held in the stage 5 registers while done is high.
// Throughput: 1 transaction per cycle, since busy stays low and every stage
// hands its data on at each edge.
// Stages: 1 wrap hues and form the level product, 2 divide by 100 into the
// upper level, 3 lower level and slope product per channel, 4 divide by 60
// and select the channel level, 5 scale by 255/100 and truncate to 8 bits.
// Zero saturation needs no special path: both levels equal lightness, so
// every channel comes out as 255*lightness/100.
// Reset clears all valid bits; data registers are not reset.

module hls_to_rgb_integer_core
  import hlsrgb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [HUE_W-1:0]  hue,
  input  logic [PCT_W-1:0]  lightness,
  input  logic [PCT_W-1:0]  saturation,
  output logic              done,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue
);

`include "hls_to_rgb_integer_core_macros.svh"

  // valid bits, one per stage
  logic [LATENCY-1:0] vld;

  // stage 1 registers
  logic [HUE_W-1:0] s1_x [3];
  logic [PCT_W-1:0] s1_l;
  logic [PCT_W-1:0] s1_s;
  logic [14:0]      s1_n;

  // stage 2 registers
  logic [HUE_W-1:0]   s2_x [3];
  logic [PCT_W-1:0]   s2_l;
  logic signed [9:0]  s2_hi;

  // stage 3 registers
  logic [14:0]        s3_p [3];
  seg_t               s3_seg [3];
  logic               s3_neg;
  logic signed [9:0]  s3_hi;
  logic signed [9:0]  s3_lo;

  // stage 4 registers
  logic signed [10:0] s4_v [3];

  // stage 5 outputs
  logic [CHAN_W-1:0]  s5_c [3];

  // stage 1 logic
  logic [HUE_W-1:0] s1_x_next [3];
  logic [14:0]      s1_n_next;
  logic [14:0]      prod_low;
  logic [14:0]      prod_high;

  // stage 2 logic
  logic [32:0]        prod_q1;
  logic [7:0]         q1;
  logic signed [9:0]  s2_hi_next;

  // stage 3 logic
  logic signed [9:0]  lo3;
  logic signed [9:0]  diff3;
  logic [8:0]         mag3;
  logic [5:0]         t3 [3];
  seg_t               seg3 [3];
  logic [14:0]        s3_p_next [3];

  // stage 4 logic
  logic [31:0]        prod_q60 [3];
  logic signed [10:0] sq4 [3];
  logic signed [10:0] s4_v_next [3];

  // stage 5 logic
  logic signed [10:0] vneg5 [3];
  logic [9:0]         mag5 [3];
  logic [17:0]        a5 [3];
  logic [35:0]        prod_o [3];
  logic [10:0]        m5 [3];
  logic [10:0]        mneg5 [3];
  logic [CHAN_W-1:0]  s5_c_next [3];

  assign busy = 1'b0;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  // stage 1: hue wrap per channel and level numerator
  always_comb begin
    s1_x_next[0] = wrap_hue($signed({2'b00, hue}) + 11'sd120);
    s1_x_next[1] = wrap_hue($signed({2'b00, hue}));
    s1_x_next[2] = wrap_hue($signed({2'b00, hue}) - 11'sd120);
    prod_low  = 15'(lightness) * (15'(saturation) + 15'(PERCENT));
    prod_high = 15'(lightness) * 15'(saturation);
    s1_n_next = (lightness <= 7'(MID_LIGHT)) ? prod_low : prod_high;
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) s1_x[c] <= s1_x_next[c];
    s1_l <= lightness;
    s1_s <= saturation;
    s1_n <= s1_n_next;
  end

  // stage 2: divide by 100, upper level
  always_comb begin
    prod_q1 = 33'(s1_n) * 33'(M100);
    q1      = prod_q1[SH100 +: 8];
    if (s1_l <= 7'(MID_LIGHT)) begin
      s2_hi_next = $signed({2'b00, q1});
    end else begin
      s2_hi_next = $signed({3'b000, s1_l}) + $signed({3'b000, s1_s})
                   - $signed({2'b00, q1});
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) s2_x[c] <= s1_x[c];
    s2_l  <= s1_l;
    s2_hi <= s2_hi_next;
  end

  // stage 3: lower level, curve piece and slope product per channel
  always_comb begin
    lo3   = $signed({2'b00, s2_l, 1'b0}) - s2_hi;
    diff3 = s2_hi - lo3;
    mag3  = diff3[9] ? 9'(-diff3) : diff3[8:0];
    for (int c = 0; c < 3; c++) begin
      if (s2_x[c] < 9'(SIXTY)) begin
        seg3[c] = SEG_RISE;
        t3[c]   = s2_x[c][5:0];
      end else if (s2_x[c] < 9'(HALF_TURN)) begin
        seg3[c] = SEG_HIGH;
        t3[c]   = '0;
      end else if (s2_x[c] < 9'(TWO_FORTY)) begin
        seg3[c] = SEG_FALL;
        t3[c]   = 6'(9'(TWO_FORTY) - s2_x[c]);
      end else begin
        seg3[c] = SEG_LOW;
        t3[c]   = '0;
      end
      s3_p_next[c] = 15'(mag3) * 15'(t3[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      s3_p[c]   <= s3_p_next[c];
      s3_seg[c] <= seg3[c];
    end
    s3_neg <= diff3[9];
    s3_hi  <= s2_hi;
    s3_lo  <= lo3;
  end

  // stage 4: divide slope product by 60 toward zero, pick channel level
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_q60[c] = 32'(s3_p[c]) * 32'(M60);
      sq4[c]      = s3_neg ? -$signed({2'b00, prod_q60[c][SH60 +: 9]})
                           :  $signed({2'b00, prod_q60[c][SH60 +: 9]});
      case (s3_seg[c])
        SEG_RISE: s4_v_next[c] = 11'(s3_lo) + sq4[c];
        SEG_FALL: s4_v_next[c] = 11'(s3_lo) + sq4[c];
        SEG_HIGH: s4_v_next[c] = 11'(s3_hi);
        SEG_LOW:  s4_v_next[c] = 11'(s3_lo);
        default:  s4_v_next[c] = 11'(s3_lo);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) s4_v[c] <= s4_v_next[c];
  end

  // stage 5: scale by 255/100 toward zero, keep low byte
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vneg5[c]     = -s4_v[c];
      mag5[c]      = s4_v[c][10] ? vneg5[c][9:0] : s4_v[c][9:0];
      a5[c]        = {mag5[c], 8'b0} - {8'b0, mag5[c]};
      prod_o[c]    = 36'(a5[c]) * 36'(M100);
      m5[c]        = prod_o[c][SH100 +: 11];
      mneg5[c]     = -m5[c];
      s5_c_next[c] = s4_v[c][10] ? mneg5[c][CHAN_W-1:0] : m5[c][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) s5_c[c] <= s5_c_next[c];
  end

  assign done  = vld[LATENCY-1];
  assign red   = s5_c[0];
  assign green = s5_c[1];
  assign blue  = s5_c[2];

  // checks
  `HRGB_ASSERT_IMP(a_latency, start && !busy, ##5 done, "result missing after accept")
  `HRGB_ASSERT_IMP(a_no_extra, done, $past(start, 5), "result without a transaction")
  `HRGB_ASSERT_IMP(a_grey, done && $past(saturation, 5) == '0, red == green && red == blue, "grey")
  `HRGB_ASSERT_IMP(a_upper_pos, vld[1], !s2_hi[9], "upper level went negative")

endmodule
